### rtl/core/wtc_pkg.sv
// shared constants, command and status types and helpers of the write-through cache
`timescale 1ns / 1ps
`default_nettype none

package wtc_pkg;

	// address split: set from line bits, word and byte within a 64-byte line
	localparam int OFF_W   = 6;
	localparam int WORD_W  = 4;
	localparam int SET_W   = 3;
	localparam int LINE_W  = 32 - OFF_W;
	localparam int TAG_W   = LINE_W - SET_W;
	localparam int WAYS_DEF = 128;

	// stream widths
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 72;

	// request opcodes
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_REFILL = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_RDATA  = 2'd0;
	localparam logic [1:0] KIND_FILL   = 2'd1;
	localparam logic [1:0] KIND_MWRITE = 2'd2;

	typedef struct packed {
		logic load_req;
		logic refill;
		logic clr_step;
		logic tag_rd;
		logic tag_cmp;
		logic way_inc;
		logic line_next;
		logic byte_rd;
		logic byte_cap;
		logic byte_wr;
		logic byte_inc;
		logic fill_req;
		logic start_fill;
		logic out_wr;
		logic out_rd;
	} wtc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic filling;
		logic refill_final;
		logic match;
		logic way_last;
		logic two_lines;
		logic line_idx;
		logic is_write;
		logic byte_last;
		logic miss_any;
		logic fill_last;
		logic out_free;
	} wtc_sts_t;

	// zero acts as one byte, five to seven as four
	function automatic logic [2:0] eff_len(input logic [2:0] l);
		logic [2:0] r;
		r = l;
		if (l == 3'd0) r = 3'd1;
		else if (l > 3'd4) r = 3'd4;
		return r;
	endfunction

	function automatic logic [31:0] len_mask(input logic [2:0] n);
		logic [31:0] m;
		case (n)
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/core/write_through_l1_cache.sv
// Usage: set-associative write-through L1 cache, 8 sets of WAYS ways, 64-byte lines.
// Slave stream carries processor reads and writes and memory refill words (tuser is the
// opcode); master stream carries read data, line fill requests and memory writes (tuser is
// the kind, tlast marks the final result of one request).
// One item at a time: a read or write walks the ways of each touched set, a tag read then a
// compare per way on the tag memory read port, stopping at a hit or the last way; then it
// handles its bytes in turn on the data memory, a write in S_BYTE and a read in S_BYTE then
// S_BYTE_CAP. A read or write holds the block until its result goes to the output register;
// the result is valid as tready returns.
// A read miss sends one fill request per missing line, then takes 16 refill words per line,
// one per cycle; the read data follows the last refill word. Reads and writes arriving
// while lines are outstanding are taken and dropped, as are stray refill words.
// After reset a clearing pass over all 8 * 2^clog2(WAYS) tag entries (at least 16, 1024 by
// default) invalidates the tag memory; tready is low during it.
// When the receiver stalls, the result waits in the output register and the block holds in
// its next output state (S_OUT_WR, S_OUT_RD or S_FILL_REQ) until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module write_through_l1_cache import wtc_pkg::*; #(
	parameter int WAYS = WAYS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// address[31:0], length[34:32], write_data[66:35], refill_word[98:67], zero fill
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// result_address[31:0], result_length[34:32], result_data[66:35], zero fill
	output logic [M_TDATA_W-1:0]      m_tdata,
	// kind[1:0]
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	wtc_cmd_t cmd;
	wtc_sts_t sts;

	// sequencing
	wtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	wtc_dp #(
		.WAYS (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.op       (s_tuser),
		.in_data  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### rtl/core/wtc_ctrl.sv
// controller state machine of the write-through cache
`timescale 1ns / 1ps
`default_nettype none

module wtc_ctrl import wtc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [1:0] op,
	input  wire wtc_sts_t   sts,
	output wtc_cmd_t        cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_TAG_RD   = 4'd2;
	localparam logic [3:0] S_TAG_CMP  = 4'd3;
	localparam logic [3:0] S_BYTE     = 4'd4;
	localparam logic [3:0] S_BYTE_CAP = 4'd5;
	localparam logic [3:0] S_OUT_WR   = 4'd6;
	localparam logic [3:0] S_OUT_RD   = 4'd7;
	localparam logic [3:0] S_FILL_REQ = 4'd8;

	logic [3:0] state_q;
	logic [3:0] nxt;

	assign s_tready = (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= nxt;
		end
	end

	// next state and commands
	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) nxt = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					if (sts.filling) begin
						if (op == OP_REFILL) begin
							cmd.refill = 1'b1;
							if (sts.refill_final) nxt = S_OUT_RD;
						end
					end else if (op == OP_READ || op == OP_WRITE) begin
						cmd.load_req = 1'b1;
						nxt = S_TAG_RD;
					end
				end
			end
			S_TAG_RD: begin
				cmd.tag_rd = 1'b1;
				nxt = S_TAG_CMP;
			end
			S_TAG_CMP: begin
				cmd.tag_cmp = 1'b1;
				if (sts.match || sts.way_last) begin
					if (!sts.line_idx && sts.two_lines) begin
						cmd.line_next = 1'b1;
						nxt = S_TAG_RD;
					end else begin
						nxt = S_BYTE;
					end
				end else begin
					cmd.way_inc = 1'b1;
					nxt = S_TAG_RD;
				end
			end
			S_BYTE: begin
				if (sts.is_write) begin
					cmd.byte_wr = 1'b1;
					if (sts.byte_last) nxt = S_OUT_WR;
					else cmd.byte_inc = 1'b1;
				end else begin
					cmd.byte_rd = 1'b1;
					nxt = S_BYTE_CAP;
				end
			end
			S_BYTE_CAP: begin
				cmd.byte_cap = 1'b1;
				if (sts.byte_last) begin
					nxt = sts.miss_any ? S_FILL_REQ : S_OUT_RD;
				end else begin
					cmd.byte_inc = 1'b1;
					nxt = S_BYTE;
				end
			end
			S_OUT_WR: begin
				if (sts.out_free) begin
					cmd.out_wr = 1'b1;
					nxt = S_IDLE;
				end
			end
			S_OUT_RD: begin
				if (sts.out_free) begin
					cmd.out_rd = 1'b1;
					nxt = S_IDLE;
				end
			end
			S_FILL_REQ: begin
				if (sts.out_free) begin
					cmd.fill_req = 1'b1;
					if (sts.fill_last) begin
						cmd.start_fill = 1'b1;
						nxt = S_IDLE;
					end
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/wtc_dp.sv
// datapath of the write-through cache: tag and data memories, fill state, result register
`timescale 1ns / 1ps
`default_nettype none

module wtc_dp import wtc_pkg::*; #(
	parameter int WAYS = WAYS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wtc_cmd_t             cmd,
	output wtc_sts_t                  sts,
	input  wire logic [1:0]           op,
	input  wire logic [S_TDATA_W-1:0] in_data,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TA_W = SET_W + WW;
	localparam int DA_W = TA_W + WORD_W;

	// request fields
	logic [31:0] in_addr, in_wdata, in_rword;
	logic [2:0]  in_len, in_n;
	logic [31:0] in_end;
	assign in_addr  = in_data[31:0];
	assign in_len   = in_data[34:32];
	assign in_wdata = in_data[66:35];
	assign in_rword = in_data[98:67];
	assign in_n     = eff_len(in_len);
	assign in_end   = in_addr + {29'd0, in_n} - 32'd1;

	// request and search state
	logic [31:0]       addr_q, wdata_q, rd_data_q;
	logic [2:0]        len_q;
	logic              wr_q, two_q, idx_q, j_q;
	logic [LINE_W-1:0] line0_q, line1_q;
	logic [WW-1:0]     way_q, victim_q;
	logic [1:0]        hit_q, ltf_q, k_q;
	logic [WW-1:0]     hway_q [2];
	logic [WW-1:0]     fway_q [2];
	logic [LINE_W-1:0] fline_q [2];
	logic [WORD_W-1:0] cnt_q;
	logic [TA_W-1:0]   clr_q;

	// memories
	logic [TAG_W:0]  tmem [2**TA_W];
	logic [31:0]     dmem [2**DA_W];
	logic [TAG_W:0]  tag_rd_q;
	logic [31:0]     dmem_rd_q;

	// result register
	logic        ov_q, olast_q;
	logic [1:0]  okind_q;
	logic [31:0] oaddr_q, odata_q;
	logic [2:0]  olen_q;

	// tag compare for the line under search
	logic [LINE_W-1:0] cur_line;
	logic [TA_W-1:0]   tag_raddr;
	logic              match;
	assign cur_line  = idx_q ? line1_q : line0_q;
	assign tag_raddr = {cur_line[SET_W-1:0], way_q};
	assign match     = tag_rd_q[TAG_W] && (tag_rd_q[TAG_W-1:0] == cur_line[LINE_W-1:SET_W]);

	// byte k of the access and the line that holds it
	logic [31:0]       ak;
	logic              bsel, bhit;
	logic [LINE_W-1:0] bline;
	logic [DA_W-1:0]   daddr_b;
	assign ak      = addr_q + {30'd0, k_q};
	assign bsel    = (ak[31:OFF_W] != line0_q);
	assign bline   = bsel ? line1_q : line0_q;
	assign bhit    = hit_q[bsel];
	assign daddr_b = {bline[SET_W-1:0], hway_q[bsel], ak[OFF_W-1:2]};

	// missing lines and victim choice
	logic [1:0]        miss_cnt;
	logic [LINE_W-1:0] mline;
	logic [WW-1:0]     v_next;
	assign miss_cnt = {1'b0, ~hit_q[0]} + {1'b0, two_q & ~hit_q[1]};
	assign mline    = (j_q || hit_q[0]) ? line1_q : line0_q;
	assign v_next   = (victim_q == WW'(WAYS - 1)) ? '0 : victim_q + WW'(1);

	// refill word and the request bytes it carries
	logic [DA_W-1:0] fill_daddr;
	logic [31:0]     fill_bytes;
	logic [3:0]      fill_be;
	logic            line_done;
	assign fill_daddr = {fline_q[0][SET_W-1:0], fway_q[0], cnt_q};
	assign line_done  = (cnt_q == {WORD_W{1'b1}});
	always_comb begin
		logic [31:0] akb;
		fill_bytes = '0;
		fill_be    = '0;
		for (int b = 0; b < 4; b++) begin
			akb = addr_q + 32'(b);
			if (3'(b) < len_q && akb[31:OFF_W] == fline_q[0] && akb[OFF_W-1:2] == cnt_q) begin
				fill_be[b]         = 1'b1;
				fill_bytes[8*b+:8] = in_rword[8*akb[1:0]+:8];
			end
		end
	end

	// tag memory write port
	logic            twe;
	logic [TA_W-1:0] twaddr;
	logic [TAG_W:0]  twdata;
	always_comb begin
		twe    = 1'b0;
		twaddr = clr_q;
		twdata = '0;
		if (cmd.clr_step) begin
			twe = 1'b1;
		end else if (cmd.fill_req) begin
			twe    = 1'b1;
			twaddr = {mline[SET_W-1:0], v_next};
		end else if (cmd.refill && line_done) begin
			twe    = 1'b1;
			twaddr = {fline_q[0][SET_W-1:0], fway_q[0]};
			twdata = {1'b1, fline_q[0][LINE_W-1:SET_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (twe) tmem[twaddr] <= twdata;
		if (cmd.tag_rd) tag_rd_q <= tmem[tag_raddr];
	end

	// data memory, byte lanes
	logic [3:0]      dwe;
	logic [DA_W-1:0] dwaddr;
	logic [31:0]     dwdata;
	always_comb begin
		dwe    = '0;
		dwaddr = daddr_b;
		dwdata = {4{wdata_q[{k_q, 3'b000}+:8]}};
		if (cmd.refill) begin
			dwe    = 4'hf;
			dwaddr = fill_daddr;
			dwdata = in_rword;
		end else if (cmd.byte_wr && bhit) begin
			dwe[ak[1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (dwe[b]) dmem[dwaddr][8*b+:8] <= dwdata[8*b+:8];
		end
		if (cmd.byte_rd) dmem_rd_q <= dmem[daddr_b];
	end

	// request payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			addr_q  <= in_addr;
			len_q   <= in_n;
			wdata_q <= in_wdata;
			line0_q <= in_addr[31:OFF_W];
			line1_q <= in_end[31:OFF_W];
			two_q   <= (in_addr[31:OFF_W] != in_end[31:OFF_W]);
		end
		if (cmd.load_req) begin
			rd_data_q <= '0;
		end else if (cmd.byte_cap && bhit) begin
			rd_data_q[{k_q, 3'b000}+:8] <= dmem_rd_q[{ak[1:0], 3'b000}+:8];
		end else if (cmd.refill) begin
			for (int b = 0; b < 4; b++) begin
				if (fill_be[b]) rd_data_q[8*b+:8] <= fill_bytes[8*b+:8];
			end
		end
		if (cmd.tag_cmp && match) hway_q[idx_q] <= way_q;
		if (cmd.fill_req) begin
			fway_q[j_q]  <= v_next;
			fline_q[j_q] <= mline;
		end else if (cmd.refill && line_done) begin
			fway_q[0]  <= fway_q[1];
			fline_q[0] <= fline_q[1];
		end
	end

	// search, fill and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= 1'b0;
			idx_q    <= 1'b0;
			way_q    <= '0;
			hit_q    <= '0;
			k_q      <= '0;
			j_q      <= 1'b0;
			victim_q <= '0;
			ltf_q    <= '0;
			cnt_q    <= '0;
			clr_q    <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + TA_W'(1);
			if (cmd.load_req) begin
				wr_q  <= (op == OP_WRITE);
				idx_q <= 1'b0;
				way_q <= '0;
				hit_q <= '0;
				k_q   <= '0;
				j_q   <= 1'b0;
			end
			if (cmd.tag_cmp && match) hit_q[idx_q] <= 1'b1;
			if (cmd.way_inc) way_q <= way_q + WW'(1);
			if (cmd.line_next) begin
				idx_q <= 1'b1;
				way_q <= '0;
			end
			if (cmd.byte_inc) k_q <= k_q + 2'd1;
			if (cmd.fill_req) begin
				j_q      <= ~j_q;
				victim_q <= v_next;
			end
			if (cmd.start_fill) begin
				ltf_q <= miss_cnt;
				cnt_q <= '0;
			end else if (cmd.refill) begin
				cnt_q <= cnt_q + WORD_W'(1);
				if (line_done) ltf_q <= ltf_q - 2'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_wr || cmd.out_rd || cmd.fill_req) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			okind_q <= KIND_MWRITE;
			oaddr_q <= addr_q;
			olen_q  <= len_q;
			odata_q <= wdata_q & len_mask(len_q);
			olast_q <= 1'b1;
		end else if (cmd.out_rd) begin
			okind_q <= KIND_RDATA;
			oaddr_q <= addr_q;
			olen_q  <= len_q;
			odata_q <= rd_data_q;
			olast_q <= 1'b1;
		end else if (cmd.fill_req) begin
			okind_q <= KIND_FILL;
			oaddr_q <= {mline, {OFF_W{1'b0}}};
			olen_q  <= '0;
			odata_q <= '0;
			olast_q <= sts.fill_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {5'd0, odata_q, olen_q, oaddr_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	// status to the controller
	always_comb begin
		sts.clr_last     = &clr_q;
		sts.filling      = (ltf_q != 2'd0);
		sts.refill_final = (ltf_q == 2'd1) && line_done;
		sts.match        = match;
		sts.way_last     = (way_q == WW'(WAYS - 1));
		sts.two_lines    = two_q;
		sts.line_idx     = idx_q;
		sts.is_write     = wr_q;
		sts.byte_last    = ({1'b0, k_q} + 3'd1 == len_q);
		sts.miss_any     = (miss_cnt != 2'd0);
		sts.fill_last    = ({1'b0, j_q} + 2'd1 == miss_cnt);
		sts.out_free     = !ov_q || m_tready;
	end

`ifndef SYNTHESIS
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ltf_q == 2'd0) |-> (cnt_q == '0))
		else $error("refill word count moved outside a fill");
	a_ltf_range: assert property (@(posedge clk) disable iff (!arst_n)
		ltf_q != 2'd3)
		else $error("more than two lines outstanding");
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.refill && ltf_q == 2'd1 && line_done) |=> (ltf_q == 2'd0))
		else $error("fill did not finish on last word");
	a_no_req_while_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> (ltf_q == 2'd0))
		else $error("request taken while lines outstanding");
`endif

endmodule

`default_nettype wire

### tb/write_through_l1_cache_chk.sv
// checker of the write-through cache: predicts results from requests and compares them
`timescale 1ns / 1ps

module write_through_l1_cache_chk import wtc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	input  wire logic [1:0]           m_tuser,
	input  wire logic                 m_tlast,
	output int                        errors,
	output int                        outstanding,
	output logic                      filling,
	output int                        reads_seen,
	output int                        fills_seen
);

	localparam int NWAYS = WAYS_DEF;
	localparam int NSLOTS = 8 * NWAYS;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [2:0]  len;
		logic [31:0] data;
		logic        last;
	} cache_result_t;

	// cache image
	logic        valid_q [NSLOTS];
	logic [22:0] tag_q   [NSLOTS];
	logic [31:0] word_q  [NSLOTS*16];
	int unsigned victim;
	logic [31:0] pend_addr;
	logic [2:0]  pend_len;
	logic [31:0] pend_data;
	int unsigned fill_way  [2];
	logic [25:0] fill_line [2];
	int unsigned fill_cnt;
	int unsigned lines_left;

	cache_result_t expected_q[$];

	assign outstanding = expected_q.size();
	assign filling = (lines_left != 0);

	function automatic logic [31:0] byte_mask(input logic [2:0] n);
		return (n >= 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * n)) - 32'd1);
	endfunction

	function automatic int find_slot(input logic [25:0] ln);
		int s;
		for (int w = 0; w < NWAYS; w++) begin
			s = ln[2:0] * NWAYS + w;
			if (valid_q[s] && tag_q[s] == ln[25:3]) return s;
		end
		return -1;
	endfunction

	function automatic cache_result_t mk(input logic [1:0] k, input logic [31:0] a,
			input logic [2:0] l, input logic [31:0] d, input logic lst);
		cache_result_t r;
		r.kind = k;
		r.addr = a;
		r.len = l;
		r.data = d;
		r.last = lst;
		return r;
	endfunction

	// one refill word into the line at the head of the fill list
	task automatic take_refill(input logic [31:0] rw);
		int slot;
		logic [31:0] ak;
		logic [31:0] d;
		slot = fill_line[0][2:0] * NWAYS + fill_way[0];
		word_q[slot * 16 + fill_cnt] = rw;
		for (int k = 0; k < pend_len; k++) begin
			ak = pend_addr + k;
			d = ak - {fill_line[0], 6'd0};
			if (ak[31:6] == fill_line[0] && d[5:2] == fill_cnt)
				pend_data |= ((rw >> (8 * d[1:0])) & 32'hff) << (8 * k);
		end
		fill_cnt++;
		if (fill_cnt == 16) begin
			tag_q[slot] = fill_line[0][25:3];
			valid_q[slot] = 1'b1;
			fill_cnt = 0;
			fill_line[0] = fill_line[1];
			fill_way[0] = fill_way[1];
			lines_left--;
			if (lines_left == 0)
				expected_q.push_back(mk(KIND_RDATA, pend_addr, pend_len,
					pend_data & byte_mask(pend_len), 1'b1));
		end
	endtask

	// processor read or write
	task automatic take_access(input logic [1:0] op, input logic [31:0] a,
			input logic [2:0] lraw, input logic [31:0] wd);
		logic [2:0]  n;
		logic [25:0] ln [2];
		logic [25:0] miss [2];
		logic [31:0] ak;
		logic [31:0] rd;
		int nl, nm, s;
		n = (lraw == 3'd0) ? 3'd1 : (lraw > 3'd4) ? 3'd4 : lraw;
		ak = a + n - 1;
		ln[0] = a[31:6];
		ln[1] = ak[31:6];
		nl = (ln[0] != ln[1]) ? 2 : 1;
		nm = 0;
		rd = '0;
		for (int i = 0; i < nl; i++) begin
			s = find_slot(ln[i]);
			if (s < 0) begin
				miss[nm] = ln[i];
				nm++;
			end else begin
				for (int k = 0; k < n; k++) begin
					ak = a + k;
					if (ak[31:6] == ln[i]) begin
						if (op == OP_WRITE)
							word_q[s * 16 + ak[5:2]][8 * ak[1:0] +: 8] = wd[8 * k +: 8];
						else
							rd[8 * k +: 8] = word_q[s * 16 + ak[5:2]][8 * ak[1:0] +: 8];
					end
				end
			end
		end
		if (op == OP_WRITE) begin
			expected_q.push_back(mk(KIND_MWRITE, a, n, wd & byte_mask(n), 1'b1));
		end else if (nm == 0) begin
			expected_q.push_back(mk(KIND_RDATA, a, n, rd, 1'b1));
		end else begin
			for (int i = 0; i < nm; i++) begin
				victim = (victim + 1) % NWAYS;
				valid_q[miss[i][2:0] * NWAYS + victim] = 1'b0;
				fill_way[i] = victim;
				fill_line[i] = miss[i];
				expected_q.push_back(mk(KIND_FILL, {miss[i], 6'd0}, 3'd0, 32'd0,
					i + 1 == nm));
			end
			pend_addr = a;
			pend_len = n;
			pend_data = rd;
			fill_cnt = 0;
			lines_left = nm;
		end
	endtask

	// predict on accepted requests, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		cache_result_t e;
		cache_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < NSLOTS; i++) valid_q[i] = 1'b0;
			victim = 0;
			fill_cnt = 0;
			lines_left = 0;
			errors = 0;
			reads_seen = 0;
			fills_seen = 0;
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (lines_left != 0) begin
					if (s_tuser == OP_REFILL) take_refill(s_tdata[98:67]);
				end else if (s_tuser == OP_READ || s_tuser == OP_WRITE) begin
					take_access(s_tuser, s_tdata[31:0], s_tdata[34:32], s_tdata[66:35]);
				end
			end
			if (m_tvalid && m_tready) begin
				got = mk(m_tuser, m_tdata[31:0], m_tdata[34:32], m_tdata[66:35], m_tlast);
				if (got.kind == KIND_RDATA) reads_seen++;
				if (got.kind == KIND_FILL) fills_seen++;
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: kind %0d addr %h", got.kind, got.addr);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (got.kind != e.kind) begin
						$error("kind: expected %h, got %h", e.kind, got.kind);
						errors++;
					end
					if (got.addr != e.addr) begin
						$error("result_address: expected %h, got %h", e.addr, got.addr);
						errors++;
					end
					if (got.len != e.len) begin
						$error("result_length: expected %h, got %h", e.len, got.len);
						errors++;
					end
					if (got.data != e.data) begin
						$error("result_data: expected %h, got %h", e.data, got.data);
						errors++;
					end
					if (got.last != e.last) begin
						$error("last: expected %h, got %h", e.last, got.last);
						errors++;
					end
				end
			end
		end
	end

endmodule

### tb/write_through_l1_cache_tb.sv
// testbench top of the write-through cache: request stimulus, stalls and verdict
`timescale 1ns / 1ps

module write_through_l1_cache_tb import wtc_pkg::*;;

	localparam int ITEMS = 1400;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	int   errors;
	int   outstanding;
	logic filling;
	int   reads_seen;
	int   fills_seen;
	logic quiet;
	int   idle_cycles;
	int   taken;

	write_through_l1_cache dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	write_through_l1_cache_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors), .outstanding(outstanding), .filling(filling),
		.reads_seen(reads_seen), .fills_seen(fills_seen)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side stalls
	initial m_tready = 1'b0;
	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 29);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one request, with a random gap in front unless in the quiet stretch
	task automatic send(input logic [1:0] op, input logic [31:0] a, input logic [2:0] l,
			input logic [31:0] wd, input logic [31:0] rw);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 29) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, rw, wd, l, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// feed refill words until every expected result has arrived
	task automatic drain();
		while (filling || outstanding != 0) begin
			if (filling) begin
				send(OP_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom, $urandom);
			end else begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// mostly a few tags so lines get hit, some near line ends and memory top
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = {21'd0, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
			6'($urandom_range(0, 63))};
		case ($urandom_range(0, 9))
			6, 7: a[5:0] = 6'($urandom_range(60, 63));
			8: a = $urandom;
			9: a = {26'h3ffffff, 6'($urandom_range(0, 63))};
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [2:0] pick_len();
		case ($urandom_range(0, 9))
			0, 1, 2: return 3'd1;
			3, 4: return 3'd2;
			5, 6, 7: return 3'd4;
			default: return 3'($urandom_range(0, 7));
		endcase
	endfunction

	initial begin
		int r;
		quiet = 1'b0;
		idle_cycles = 0;
		taken = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_READ;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: miss, fill, hit, partial update, line spans, odd lengths, wrap, noise
		send(OP_WRITE, 32'h0, 3'd4, 32'hdead_beef, 32'h0);
		send(OP_READ, 32'h0, 3'd4, 32'h0, 32'h0);
		drain();
		send(OP_READ, 32'h0, 3'd4, 32'h0, 32'h0);
		send(OP_WRITE, 32'h2, 3'd2, 32'hffff_a55a, 32'h0);
		send(OP_READ, 32'h1, 3'd3, 32'h0, 32'h0);
		send(OP_READ, 32'h3e, 3'd4, 32'h0, 32'h0);
		drain();
		send(OP_WRITE, 32'h3f, 3'd4, 32'hffff_ffff, 32'h0);
		send(OP_READ, 32'h3c, 3'd7, 32'h0, 32'h0);
		send(OP_READ, 32'h3f, 3'd0, 32'h0, 32'h0);
		send(OP_READ, 32'hffff_fffe, 3'd4, 32'h0, 32'h0);
		drain();
		send(OP_WRITE, 32'hffff_ffff, 3'd5, 32'hffff_ffff, 32'h0);
		send(OP_READ, 32'hffff_fffc, 3'd4, 32'h0, 32'h0);
		send(OP_UNUSED, 32'hffff_ffff, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
		send(OP_REFILL, 32'h0, 3'd1, 32'h0, 32'hffff_ffff);
		send(OP_READ, 32'hffff_ff80, 3'd1, 32'h0, 32'h0);
		send(OP_READ, 32'h0000_1234, 3'd2, 32'h0, 32'h0);
		send(OP_REFILL, 32'h0, 3'd1, 32'h0, 32'h0);
		drain();

		// random traffic, refills answered while lines are outstanding
		while (taken < ITEMS) begin
			quiet = (taken >= 400 && taken < 650);
			if (taken == 800) begin
				drain();
				repeat (40) @(negedge clk);
			end
			r = $urandom_range(0, 99);
			if (filling) begin
				if (r < 85) begin
					send(OP_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom, $urandom);
				end else begin
					send(2'($urandom_range(0, 3)), pick_addr(), pick_len(), $urandom,
						$urandom);
				end
			end else if (r < 45) begin
				send(OP_READ, pick_addr(), pick_len(), $urandom, $urandom);
			end else if (r < 88) begin
				send(OP_WRITE, pick_addr(), pick_len(), $urandom, $urandom);
			end else begin
				send(r[0] ? OP_REFILL : OP_UNUSED, $urandom, 3'($urandom_range(0, 7)),
					$urandom, $urandom);
			end
			taken++;
		end
		quiet = 1'b0;
		drain();
		repeat (600) @(posedge clk);

		$display("covered %0d requests, %0d read results, %0d line fills", taken,
			reads_seen, fills_seen);
		if (errors == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### write_through_l1_cache.f
rtl/core/wtc_pkg.sv
rtl/core/wtc_ctrl.sv
rtl/core/wtc_dp.sv
rtl/core/write_through_l1_cache.sv
tb/write_through_l1_cache_chk.sv
tb/write_through_l1_cache_tb.sv
